// ===== design/i2cm_pkg.sv =====
package i2cm_pkg;

    localparam int MAX_BURST_DEF   = 16;
    localparam logic [7:0] DELAY_RESET = 8'd15;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BUSY    = 2'd1;
    localparam logic [1:0] ST_BUS_ERR = 2'd2;
    localparam logic [1:0] ST_NO_ACK  = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic       is_read;
        logic [7:0] device_addr;
        logic [7:0] reg_addr;
        logic [4:0] byte_count;
        logic [7:0] write_data;
        logic       sda_in;
    } t_item;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       read_valid;
        logic [7:0] read_data;
        logic       read_last;
        logic       done_res;
        logic [1:0] status;
        logic       ready_res;
    } t_result;

endpackage

// ===== design/i2cm_wbuf.sv =====
module i2cm_wbuf #(
    parameter int MAX_BURST = 16,
    parameter int BW        = $clog2(MAX_BURST + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load_en,
    input  logic [7:0]    i_load_data,
    input  logic          i_clear,
    input  logic [BW-1:0] i_rd_idx,
    output logic [7:0]    o_rd_data,
    output logic [BW-1:0] o_fill
);
    localparam int IW = (MAX_BURST > 1) ? $clog2(MAX_BURST) : 1;

    logic [7:0]    r_mem [MAX_BURST];
    logic [BW-1:0] r_fill;
    logic          w_room;

    assign w_room = (r_fill < BW'(MAX_BURST));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_clear) begin
            r_fill <= '0;
        end else if (i_load_en && w_room) begin
            r_fill <= r_fill + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load_en && w_room) begin
            r_mem[r_fill[IW-1:0]] <= i_load_data;
        end
    end

    // entries past the fill level read as zero
    assign o_rd_data = (i_rd_idx < r_fill) ? r_mem[i_rd_idx[IW-1:0]] : 8'h00;
    assign o_fill    = r_fill;

endmodule

// ===== design/i2cm_core.sv =====
module i2cm_core #(
    parameter int MAX_BURST = 16,
    parameter int BW        = $clog2(MAX_BURST + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  i2cm_pkg::t_item  i_item,
    input  logic [7:0]       i_delay_ticks,
    output i2cm_pkg::t_result o_result,
    output logic             o_load_en,
    output logic [7:0]       o_load_data,
    output logic             o_buf_clear,
    output logic [BW-1:0]    o_rd_idx,
    input  logic [7:0]       i_rd_data
);
    import i2cm_pkg::*;

    localparam int CW = (BW > 5) ? BW : 5;

    typedef enum logic [3:0] {
        PH_IDLE, PH_START_A, PH_START_B, PH_TX_LOW, PH_TX_DATA, PH_TX_HIGH,
        PH_TX_ACKLOW, PH_TX_ACKHIGH, PH_RX_LOW, PH_RX_HIGH, PH_RX_ACKLOW,
        PH_RX_ACKHIGH, PH_RX_ACKTAIL, PH_STOP_A, PH_STOP_B
    } t_phase;

    typedef enum logic [1:0] {SG_DEV, SG_REG, SG_DATA, SG_RADDR} t_stage;

    t_phase        r_phase, n_phase;
    t_stage        r_stage, n_stage;
    logic [7:0]    r_delay, n_delay;
    logic [3:0]    r_bits, n_bits;
    logic [BW-1:0] r_done_cnt, n_done_cnt;
    logic [7:0]    r_shift, n_shift;
    logic [7:0]    r_dev, n_dev;
    logic [7:0]    r_reg, n_reg;
    logic [BW-1:0] r_count, n_count;
    logic          r_rd, n_rd;
    logic [1:0]    r_status, n_status;
    logic          r_scl, n_scl;
    logic          r_sda, n_sda;

    logic [7:0]    w_eff_delay;
    logic [7:0]    w_dc;
    logic [CW-1:0] w_cnt;
    logic [BW:0]   w_next_done;
    logic          w_last;
    logic [7:0]    w_rx_byte;
    logic          do_send, do_recv, do_stop, do_start, do_after_start;
    logic [7:0]    send_val;
    logic          out_valid, out_last, out_done;
    logic [7:0]    out_data;

    assign w_eff_delay = (i_delay_ticks == 8'd0) ? 8'd1 : i_delay_ticks;
    assign w_dc        = (r_delay != 8'd0) ? r_delay - 8'd1 : 8'd0;
    assign w_next_done = {1'b0, r_done_cnt} + 1'b1;
    assign w_last      = (w_next_done >= {1'b0, r_count});
    assign w_rx_byte   = {r_shift[6:0], i_item.sda_in};
    assign o_rd_idx    = (r_stage == SG_DATA) ? w_next_done[BW-1:0] : '0;

    always_comb begin
        n_phase    = r_phase;
        n_stage    = r_stage;
        n_delay    = r_delay;
        n_bits     = r_bits;
        n_done_cnt = r_done_cnt;
        n_shift    = r_shift;
        n_dev      = r_dev;
        n_reg      = r_reg;
        n_count    = r_count;
        n_rd       = r_rd;
        n_status   = r_status;
        n_scl      = r_scl;
        n_sda      = r_sda;
        do_send    = 1'b0;
        do_recv    = 1'b0;
        do_stop    = 1'b0;
        do_start   = 1'b0;
        do_after_start = 1'b0;
        send_val   = 8'h00;
        out_valid  = 1'b0;
        out_data   = 8'h00;
        out_last   = 1'b0;
        out_done   = 1'b0;
        o_load_en  = 1'b0;
        o_buf_clear = 1'b0;
        w_cnt      = CW'(i_item.byte_count);
        if (w_cnt == '0) begin
            w_cnt = CW'(1);
        end
        if (w_cnt > CW'(MAX_BURST)) begin
            w_cnt = CW'(MAX_BURST);
        end

        if (i_step) begin
            case (i_item.kind)
                KIND_LOAD: begin
                    o_load_en = (r_phase == PH_IDLE);
                end
                KIND_START: begin
                    if (r_phase == PH_IDLE) begin
                        n_dev      = i_item.device_addr;
                        n_reg      = i_item.reg_addr;
                        n_count    = w_cnt[BW-1:0];
                        n_rd       = i_item.is_read;
                        n_status   = ST_OK;
                        n_stage    = SG_DEV;
                        n_done_cnt = '0;
                        do_start   = 1'b1;
                    end
                end
                KIND_TICK: begin
                    if (r_phase != PH_IDLE) begin
                        n_delay = w_dc;
                        if (w_dc == 8'd0) begin
                            case (r_phase)
                                PH_START_A: begin
                                    if (!i_item.sda_in) begin
                                        if (r_status == ST_OK) n_status = ST_BUSY;
                                        do_after_start = 1'b1;
                                    end else begin
                                        n_sda   = 1'b0;
                                        n_phase = PH_START_B;
                                        n_delay = w_eff_delay;
                                    end
                                end
                                PH_START_B: begin
                                    if (i_item.sda_in && r_status == ST_OK) begin
                                        n_status = ST_BUS_ERR;
                                    end
                                    do_after_start = 1'b1;
                                end
                                PH_TX_LOW: begin
                                    n_sda   = r_shift[7];
                                    n_shift = {r_shift[6:0], 1'b0};
                                    n_phase = PH_TX_DATA;
                                    n_delay = w_eff_delay;
                                end
                                PH_TX_DATA: begin
                                    n_scl   = 1'b1;
                                    n_phase = PH_TX_HIGH;
                                    n_delay = w_eff_delay;
                                end
                                PH_TX_HIGH: begin
                                    n_bits  = r_bits + 4'd1;
                                    n_scl   = 1'b0;
                                    n_delay = w_eff_delay;
                                    if (n_bits < 4'd8) begin
                                        n_phase = PH_TX_LOW;
                                    end else begin
                                        n_sda   = 1'b1;
                                        n_phase = PH_TX_ACKLOW;
                                    end
                                end
                                PH_TX_ACKLOW: begin
                                    n_scl   = 1'b1;
                                    n_phase = PH_TX_ACKHIGH;
                                    n_delay = w_eff_delay;
                                end
                                PH_TX_ACKHIGH: begin
                                    if (i_item.sda_in && r_status == ST_OK) begin
                                        n_status = ST_NO_ACK;
                                    end
                                    n_scl = 1'b0;
                                    case (r_stage)
                                        SG_DEV: begin
                                            n_stage  = SG_REG;
                                            do_send  = 1'b1;
                                            send_val = r_reg;
                                        end
                                        SG_REG: begin
                                            if (r_rd) begin
                                                n_stage  = SG_RADDR;
                                                do_start = 1'b1;
                                            end else begin
                                                n_stage    = SG_DATA;
                                                n_done_cnt = '0;
                                                do_send    = 1'b1;
                                                send_val   = i_rd_data;
                                            end
                                        end
                                        SG_DATA: begin
                                            n_done_cnt = w_next_done[BW-1:0];
                                            if (!w_last) begin
                                                do_send  = 1'b1;
                                                send_val = i_rd_data;
                                            end else begin
                                                do_stop = 1'b1;
                                            end
                                        end
                                        default: begin
                                            n_done_cnt = '0;
                                            do_recv    = 1'b1;
                                        end
                                    endcase
                                end
                                PH_RX_LOW: begin
                                    n_scl   = 1'b1;
                                    n_phase = PH_RX_HIGH;
                                    n_delay = w_eff_delay;
                                end
                                PH_RX_HIGH: begin
                                    n_shift = w_rx_byte;
                                    n_bits  = r_bits + 4'd1;
                                    n_scl   = 1'b0;
                                    n_delay = w_eff_delay;
                                    if (n_bits < 4'd8) begin
                                        n_phase = PH_RX_LOW;
                                    end else begin
                                        out_valid = 1'b1;
                                        out_data  = w_rx_byte;
                                        out_last  = w_last;
                                        n_sda     = w_last;
                                        n_phase   = PH_RX_ACKLOW;
                                    end
                                end
                                PH_RX_ACKLOW: begin
                                    n_scl   = 1'b1;
                                    n_phase = PH_RX_ACKHIGH;
                                    n_delay = w_eff_delay;
                                end
                                PH_RX_ACKHIGH: begin
                                    n_scl   = 1'b0;
                                    n_phase = PH_RX_ACKTAIL;
                                    n_delay = w_eff_delay;
                                end
                                PH_RX_ACKTAIL: begin
                                    n_done_cnt = w_next_done[BW-1:0];
                                    if (!w_last) begin
                                        do_recv = 1'b1;
                                    end else begin
                                        do_stop = 1'b1;
                                    end
                                end
                                PH_STOP_A: begin
                                    n_sda   = 1'b1;
                                    n_phase = PH_STOP_B;
                                    n_delay = w_eff_delay;
                                end
                                PH_STOP_B: begin
                                    out_done    = 1'b1;
                                    o_buf_clear = !r_rd;
                                    n_phase     = PH_IDLE;
                                end
                                default: begin
                                    n_phase = PH_IDLE;
                                end
                            endcase
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        if (do_after_start) begin
            do_send  = 1'b1;
            send_val = (r_stage == SG_RADDR) ? r_dev + 8'd1 : r_dev;
        end
        if (do_start) begin
            n_sda   = 1'b1;
            n_scl   = 1'b1;
            n_phase = PH_START_A;
            n_delay = w_eff_delay;
        end
        if (do_send) begin
            n_shift = send_val;
            n_bits  = 4'd0;
            n_scl   = 1'b0;
            n_phase = PH_TX_LOW;
            n_delay = w_eff_delay;
        end
        if (do_recv) begin
            n_sda   = 1'b1;
            n_scl   = 1'b0;
            n_shift = 8'h00;
            n_bits  = 4'd0;
            n_phase = PH_RX_LOW;
            n_delay = w_eff_delay;
        end
        if (do_stop) begin
            n_sda   = 1'b0;
            n_scl   = 1'b1;
            n_phase = PH_STOP_A;
            n_delay = w_eff_delay;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_stage    <= SG_DEV;
            r_delay    <= '0;
            r_bits     <= '0;
            r_done_cnt <= '0;
            r_shift    <= '0;
            r_dev      <= '0;
            r_reg      <= '0;
            r_count    <= '0;
            r_rd       <= 1'b0;
            r_status   <= ST_OK;
            r_scl      <= 1'b1;
            r_sda      <= 1'b1;
        end else begin
            r_phase    <= n_phase;
            r_stage    <= n_stage;
            r_delay    <= n_delay;
            r_bits     <= n_bits;
            r_done_cnt <= n_done_cnt;
            r_shift    <= n_shift;
            r_dev      <= n_dev;
            r_reg      <= n_reg;
            r_count    <= n_count;
            r_rd       <= n_rd;
            r_status   <= n_status;
            r_scl      <= n_scl;
            r_sda      <= n_sda;
        end
    end

    assign o_load_data          = i_item.write_data;
    assign o_result.scl_out     = n_scl;
    assign o_result.sda_out     = n_sda;
    assign o_result.read_valid  = out_valid;
    assign o_result.read_data   = out_data;
    assign o_result.read_last   = out_last;
    assign o_result.done_res    = out_done;
    assign o_result.status      = n_status;
    assign o_result.ready_res   = (n_phase == PH_IDLE);

endmodule

// ===== design/i2c_master_register_access_unit.sv =====
// channel | valid      | ready       | word
// --------+------------+-------------+-------------------------------------------
// cfg     | i_cfg_valid| o_cfg_ready | i_cfg_delay_ticks
// in      | i_in_valid | o_in_ready  | i_kind .. i_sda_in
// out     | o_out_valid| i_out_ready | o_scl_out .. o_ready_res
//
// One word per cycle while the output is not stalled: each input word is
// registered, stepped through the bus sequencer and its result lands in the
// output register.
// Reset is synchronous, active low; no clearing pass is needed.
// A stalled output holds its word; the input register still accepts while
// the output word is taken in the same cycle.
module i2c_master_register_access_unit #(
    parameter int MAX_BURST = i2cm_pkg::MAX_BURST_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_delay_ticks,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_kind,
    input  logic       i_is_read,
    input  logic [7:0] i_device_addr,
    input  logic [7:0] i_reg_addr,
    input  logic [4:0] i_byte_count,
    input  logic [7:0] i_write_data,
    input  logic       i_sda_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_scl_out,
    output logic       o_sda_out,
    output logic       o_read_valid,
    output logic [7:0] o_read_data,
    output logic       o_read_last,
    output logic       o_done_res,
    output logic [1:0] o_status,
    output logic       o_ready_res
);
    import i2cm_pkg::*;

    localparam int BW = $clog2(MAX_BURST + 1);

    logic [7:0]    r_delay_ticks;
    logic          r_in_valid;
    t_item         r_item;
    logic          r_out_valid;
    t_result       r_result;
    t_result       w_result;
    logic          w_adv;
    logic          w_load_en;
    logic [7:0]    w_load_data;
    logic          w_clear;
    logic [BW-1:0] w_rd_idx;
    logic [7:0]    w_rd_data;
    logic [BW-1:0] w_fill;

    assign w_adv       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_ticks <= DELAY_RESET;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_delay_ticks <= i_cfg_delay_ticks;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= '{kind: i_kind, is_read: i_is_read, device_addr: i_device_addr,
                        reg_addr: i_reg_addr, byte_count: i_byte_count,
                        write_data: i_write_data, sda_in: i_sda_in};
        end
        if (w_adv) begin
            r_result <= w_result;
        end
    end

    i2cm_wbuf #(
        .MAX_BURST (MAX_BURST),
        .BW        (BW)
    ) u_wbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load_en   (w_load_en),
        .i_load_data (w_load_data),
        .i_clear     (w_clear),
        .i_rd_idx    (w_rd_idx),
        .o_rd_data   (w_rd_data),
        .o_fill      (w_fill)
    );

    i2cm_core #(
        .MAX_BURST (MAX_BURST),
        .BW        (BW)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_adv),
        .i_item        (r_item),
        .i_delay_ticks (r_delay_ticks),
        .o_result      (w_result),
        .o_load_en     (w_load_en),
        .o_load_data   (w_load_data),
        .o_buf_clear   (w_clear),
        .o_rd_idx      (w_rd_idx),
        .i_rd_data     (w_rd_data & {8{w_fill != '0}})
    );

    assign o_out_valid  = r_out_valid;
    assign o_scl_out    = r_result.scl_out;
    assign o_sda_out    = r_result.sda_out;
    assign o_read_valid = r_result.read_valid;
    assign o_read_data  = r_result.read_data;
    assign o_read_last  = r_result.read_last;
    assign o_done_res   = r_result.done_res;
    assign o_status     = r_result.status;
    assign o_ready_res  = r_result.ready_res;

endmodule
